/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// cons must hold in every cycle in which ante holds
`define SDF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdf implication check failed");
// cond must never hold out of reset
`define SDF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sdf never check failed");
`else
`define SDF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SDF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/sdf_pkg.sv */
package sdf_pkg;

  localparam int VAL_W      = 64;
  localparam int MAX_FIELD  = 32;
  localparam int RESULT_CAP = 32;
  localparam int CAP        = (MAX_FIELD < RESULT_CAP) ? MAX_FIELD : RESULT_CAP;
  localparam int LEN_W      = 6;
  localparam int DIGITS     = 20;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int STEP_BITS  = 4;
  localparam int CONV_STEPS = VAL_W / STEP_BITS;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int NAT_W      = $clog2(DIGITS + 1);

  localparam logic [2:0] REG_FIELD_WIDTH = 3'd0;
  localparam logic [2:0] REG_PRECISION   = 3'd1;
  localparam logic [2:0] REG_SIGN_MODE   = 3'd2;
  localparam logic [2:0] REG_LEFT_ADJUST = 3'd3;
  localparam logic [2:0] REG_ZERO_PAD    = 3'd4;

  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [5:0]        min_width;
    logic signed [5:0] precision;
    logic [1:0]        sign_mode;
    logic              pad_right;
    logic              zero_pad;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [VAL_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic [7:0]       char_code;
    logic             last;
    logic             empty_res;
    logic [LEN_W-1:0] length;
  } res_t;

endpackage

/* rtl/sdf_front.sv */
module sdf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [sdf_pkg::VAL_W-1:0] value,
  output logic                          full,
  input  logic                          q_full,
  output logic                          q_push,
  output sdf_pkg::item_t                q_item
);

  logic           valid_r, valid_nxt;
  sdf_pkg::item_t item_r, item_nxt;
  logic           accept;

  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_item = item_r;

  // magnitude in unsigned arithmetic, so the most negative value is exact
  always_comb begin
    item_nxt      = item_r;
    valid_nxt     = valid_r && !q_push;
    if (accept) begin
      item_nxt.neg  = value[sdf_pkg::VAL_W-1];
      item_nxt.zero = (value == '0);
      item_nxt.mag  = value[sdf_pkg::VAL_W-1] ? (~value + 1'b1) : value;
      valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

/* rtl/sdf_queue.sv */
module sdf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdf_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sdf_pkg::item_t rd_item
);

  sdf_pkg::item_t mem_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

/* rtl/sdf_back.sv */
module sdf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sdf_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  sdf_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           res_pop,
  output logic           res_empty,
  output sdf_pkg::res_t  res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam int LW = sdf_pkg::LEN_W;

  state_t                          state_r, state_nxt;
  logic [sdf_pkg::VAL_W-1:0]       sh_r, sh_nxt;
  logic [sdf_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [sdf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            neg_r, neg_nxt;
  logic                            zero_r, zero_nxt;
  logic [sdf_pkg::NAT_W-1:0]       nat_r, nat_nxt;
  logic [LW-1:0]                   len_r, len_nxt;
  logic [LW-1:0]                   pad_r, pad_nxt;
  logic [LW-1:0]                   content_r, content_nxt;
  logic [LW-1:0]                   end_r, end_nxt;
  logic                            has_sign_r, has_sign_nxt;
  logic [7:0]                      sign_ch_r, sign_ch_nxt;
  logic [LW-1:0]                   k_r, k_nxt;

  // calc-stage terms
  logic [sdf_pkg::NAT_W-1:0]       nat_c;
  logic [4:0]                      pre_c;
  logic [LW-1:0]                   ndig_c, fw_c, tot_c, content_c;
  logic                            has_sign_c;
  logic [7:0]                      sign_ch_c;

  // emit-stage terms
  logic [LW-1:0]                   r_c;
  logic [3:0]                      dsel_c;
  logic [7:0]                      dch_c;
  sdf_pkg::res_t                   res_c;
  logic                            emit_fire;

  // result buffer
  sdf_pkg::res_t                   ob_r [2];
  logic                            ob_wp_r, ob_wp_nxt;
  logic                            ob_rp_r, ob_rp_nxt;
  logic [1:0]                      ob_cnt_r, ob_cnt_nxt;
  logic                            ob_full, ob_pop;

  // one double-dabble step per input bit
  function automatic logic [sdf_pkg::BCD_W-1:0] dabble(
    input logic [sdf_pkg::BCD_W-1:0] b,
    input logic                      bit_in
  );
    logic [sdf_pkg::BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < sdf_pkg::DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[sdf_pkg::BCD_W-2:0], bit_in};
  endfunction

  assign ob_full   = (ob_cnt_r == 2'd2);
  assign res_empty = (ob_cnt_r == 2'd0);
  assign ob_pop    = res_pop && !res_empty;
  assign res       = ob_r[ob_rp_r];
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign emit_fire = (state_r == ST_EMIT) && !ob_full;

  // layout of the field
  always_comb begin
    nat_c = sdf_pkg::NAT_W'(1);
    for (int i = 1; i < sdf_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        nat_c = sdf_pkg::NAT_W'(i + 1);
      end
    end
    pre_c = cfg.precision[5] ? 5'd0 : cfg.precision[4:0];
    if (zero_r && cfg.precision == 6'sd0) begin
      ndig_c = '0;
    end else if (LW'(nat_c) > LW'(pre_c)) begin
      ndig_c = LW'(nat_c);
    end else begin
      ndig_c = LW'(pre_c);
    end
    if (neg_r) begin
      sign_ch_c = sdf_pkg::CH_MINUS;
    end else if (cfg.sign_mode == sdf_pkg::SIGN_PLUS) begin
      sign_ch_c = sdf_pkg::CH_PLUS;
    end else if (cfg.sign_mode == sdf_pkg::SIGN_SPACE) begin
      sign_ch_c = sdf_pkg::CH_SPACE;
    end else begin
      sign_ch_c = sdf_pkg::CH_NUL;
    end
    has_sign_c = (sign_ch_c != sdf_pkg::CH_NUL);
    content_c  = ndig_c + LW'(has_sign_c);
    fw_c       = (cfg.min_width > LW'(sdf_pkg::CAP)) ? LW'(sdf_pkg::CAP) : cfg.min_width;
    tot_c      = (content_c > fw_c) ? content_c : fw_c;
  end

  // character at position k_r
  always_comb begin
    r_c    = end_r - LW'(1) - k_r;
    dsel_c = 4'd0;
    for (int i = 0; i < sdf_pkg::DIGITS; i++) begin
      if (r_c == LW'(i)) begin
        dsel_c = bcd_r[4*i +: 4];
      end
    end
    dch_c = (r_c < LW'(nat_r)) ? (sdf_pkg::CH_ZERO + {4'd0, dsel_c}) : sdf_pkg::CH_ZERO;

    res_c.length    = len_r;
    res_c.empty_res = (len_r == '0);
    res_c.last      = (len_r == '0) || (k_r == len_r - LW'(1));
    if (len_r == '0) begin
      res_c.char_code = sdf_pkg::CH_NUL;
    end else if (cfg.zero_pad) begin
      res_c.char_code = (has_sign_r && k_r == '0) ? sign_ch_r : dch_c;
    end else if (!cfg.pad_right) begin
      if (k_r < pad_r) begin
        res_c.char_code = sdf_pkg::CH_SPACE;
      end else if (has_sign_r && k_r == pad_r) begin
        res_c.char_code = sign_ch_r;
      end else begin
        res_c.char_code = dch_c;
      end
    end else begin
      if (has_sign_r && k_r == '0) begin
        res_c.char_code = sign_ch_r;
      end else if (k_r >= content_r) begin
        res_c.char_code = sdf_pkg::CH_SPACE;
      end else begin
        res_c.char_code = dch_c;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sh_nxt       = sh_r;
    bcd_nxt      = bcd_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    zero_nxt     = zero_r;
    nat_nxt      = nat_r;
    len_nxt      = len_r;
    pad_nxt      = pad_r;
    content_nxt  = content_r;
    end_nxt      = end_r;
    has_sign_nxt = has_sign_r;
    sign_ch_nxt  = sign_ch_r;
    k_nxt        = k_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          sh_nxt    = q_item.mag;
          neg_nxt   = q_item.neg;
          zero_nxt  = q_item.zero;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_r;
        for (int j = 0; j < sdf_pkg::STEP_BITS; j++) begin
          bcd_nxt = dabble(bcd_nxt, sh_r[sdf_pkg::VAL_W-1-j]);
        end
        sh_nxt  = sh_r << sdf_pkg::STEP_BITS;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == sdf_pkg::CNT_W'(sdf_pkg::CONV_STEPS - 1)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        nat_nxt      = nat_c;
        content_nxt  = content_c;
        pad_nxt      = tot_c - content_c;
        len_nxt      = (tot_c > LW'(sdf_pkg::CAP)) ? LW'(sdf_pkg::CAP) : tot_c;
        end_nxt      = (cfg.pad_right && !cfg.zero_pad) ? content_c : tot_c;
        has_sign_nxt = has_sign_c;
        sign_ch_nxt  = sign_ch_c;
        k_nxt        = '0;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          k_nxt = k_r + LW'(1);
          if (res_c.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ob_wp_nxt  = ob_wp_r ^ emit_fire;
    ob_rp_nxt  = ob_rp_r ^ ob_pop;
    ob_cnt_nxt = ob_cnt_r + {1'b0, emit_fire} - {1'b0, ob_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ob_wp_r  <= 1'b0;
      ob_rp_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      ob_wp_r  <= ob_wp_nxt;
      ob_rp_r  <= ob_rp_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
    sh_r       <= sh_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    nat_r      <= nat_nxt;
    len_r      <= len_nxt;
    pad_r      <= pad_nxt;
    content_r  <= content_nxt;
    end_r      <= end_nxt;
    has_sign_r <= has_sign_nxt;
    sign_ch_r  <= sign_ch_nxt;
    k_r        <= k_nxt;
    if (emit_fire) begin
      ob_r[ob_wp_r] <= res_c;
    end
  end

endmodule

/* rtl/signed_decimal_field_formatter.sv */
// Formats signed 64-bit integers as printf-style decimal text, one ASCII
// character per result.
// Input: drive in_value and raise in_push; the transfer happens on a clock
// edge with in_push high and in_full low. An input register and a two-entry
// queue let up to three values wait while one is being formatted.
// Results: while out_empty is low the oldest character is on out_char_code,
// out_last, out_empty_res and out_length; out_pop takes it. An empty string
// gives one result with out_empty_res set. If the receiver stalls, a
// two-entry result buffer fills, the formatter holds, and then in_full rises.
// Configuration: cfg_valid/cfg_ready (ready always high) with cfg_index and
// cfg_wdata; write only while no value is in flight.
// Steps: each value passes through the 4-bit-per-cycle binary-to-BCD
// converter, then one layout step, then emits one character per cycle (one
// result for an empty string) while the result buffer has room.
// Reset: synchronous, active low; clears all queues and sets the registers
// to width 0, precision not given, no sign, right adjust, space padding.
`include "assert_macros.svh"

module signed_decimal_field_formatter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  logic signed [sdf_pkg::VAL_W-1:0]      in_value,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [7:0]                            out_char_code,
  output logic                                  out_last,
  output logic                                  out_empty_res,
  output logic [sdf_pkg::LEN_W-1:0]             out_length,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_index,
  input  logic [5:0]                            cfg_wdata
);

  sdf_pkg::cfg_t  cfg_r, cfg_nxt;
  sdf_pkg::item_t fr_item, q_item;
  sdf_pkg::res_t  res;
  logic           fr_push, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdf_pkg::REG_FIELD_WIDTH: cfg_nxt.min_width   = cfg_wdata;
        sdf_pkg::REG_PRECISION:   cfg_nxt.precision   = cfg_wdata;
        sdf_pkg::REG_SIGN_MODE:   cfg_nxt.sign_mode   = cfg_wdata[1:0];
        sdf_pkg::REG_LEFT_ADJUST: cfg_nxt.pad_right   = cfg_wdata[0];
        sdf_pkg::REG_ZERO_PAD:    cfg_nxt.zero_pad    = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width   <= 6'd0;
      cfg_r.precision   <= -6'sd1;
      cfg_r.sign_mode   <= 2'd0;
      cfg_r.pad_right   <= 1'b0;
      cfg_r.zero_pad    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sdf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .value  (in_value),
    .full   (in_full),
    .q_full (q_full),
    .q_push (fr_push),
    .q_item (fr_item)
  );

  sdf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_item (fr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_char_code = res.char_code;
  assign out_last      = res.last;
  assign out_empty_res = res.empty_res;
  assign out_length    = res.length;

  `SDF_ASSERT_IMPLY(a_len_cap, clk, rst_n, !out_empty, out_length <= sdf_pkg::LEN_W'(sdf_pkg::CAP))
  `SDF_ASSERT_IMPLY(a_empty_str, clk, rst_n, !out_empty && out_empty_res, out_last && out_length == '0 && out_char_code == sdf_pkg::CH_NUL)
  `SDF_ASSERT_IMPLY(a_nonempty_len, clk, rst_n, !out_empty && !out_empty_res, out_length != '0)
  `SDF_ASSERT_NEVER(a_pop_no_item, clk, rst_n, q_pop && q_empty)

endmodule

/* verif/signed_decimal_field_formatter_test.sv */
`timescale 1ns / 100ps

module signed_decimal_field_formatter_test;

  localparam logic [1:0] SIGN_NONE   = 2'd0;
  localparam logic [1:0] SIGN_UNUSED = 2'd3;
  localparam int DIR_ROWS = 23;

  typedef struct packed {
    sdf_pkg::cfg_t cfg;
    logic [63:0]   value;
    logic          typed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [63:0] in_value = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_char_code;
  logic        out_last;
  logic        out_empty_res;
  logic [sdf_pkg::LEN_W-1:0] out_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = sdf_pkg::REG_FIELD_WIDTH;
  logic [5:0]  cfg_wdata = '0;

  sdf_pkg::cfg_t fmt_cfg = '{6'd0, 6'h3F, SIGN_NONE, 1'b0, 1'b0};
  sdf_pkg::res_t pending_chars [$];
  int   mismatch_count = 0;
  int   send_idle_pct = 30;
  int   pop_stall_pct = 52;

  // Directed rows. Rows with typed set carry their text in dir_text.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{6'd0,  6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'd0,                  1'b1},
    '{'{6'd0,  6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    '{'{6'd0,  6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'h8000_0000_0000_0000, 1'b1},
    '{'{6'd0,  6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{'{6'd0,  6'd0,  SIGN_NONE,           1'b0, 1'b0}, 64'd0,                  1'b1},
    '{'{6'd0,  6'd0,  sdf_pkg::SIGN_PLUS,  1'b0, 1'b0}, 64'd0,                  1'b1},
    '{'{6'd0,  6'd0,  sdf_pkg::SIGN_SPACE, 1'b0, 1'b0}, 64'd0,                  1'b1},
    '{'{6'd0,  6'd0,  SIGN_UNUSED,         1'b0, 1'b0}, 64'd5,                  1'b1},
    '{'{6'd5,  6'h3F, sdf_pkg::SIGN_PLUS,  1'b0, 1'b0}, 64'd42,                 1'b1},
    '{'{6'd5,  6'h3F, SIGN_NONE,           1'b1, 1'b0}, -64'sd42,               1'b1},
    '{'{6'd6,  6'h3F, sdf_pkg::SIGN_SPACE, 1'b0, 1'b1}, 64'd42,                 1'b1},
    '{'{6'd6,  6'h3F, SIGN_NONE,           1'b1, 1'b1}, -64'sd7,                1'b1},
    '{'{6'd8,  6'd3,  SIGN_NONE,           1'b0, 1'b1}, 64'd5,                  1'b1},
    '{'{6'd0,  6'd31, SIGN_NONE,           1'b0, 1'b0}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{'{6'd0,  6'd31, sdf_pkg::SIGN_PLUS,  1'b0, 1'b0}, 64'h8000_0000_0000_0000, 1'b0},
    '{'{6'd32, 6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'd1,                  1'b0},
    '{'{6'd63, 6'h3F, SIGN_NONE,           1'b1, 1'b0}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{'{6'd63, 6'h20, SIGN_NONE,           1'b0, 1'b1}, 64'd123,                1'b0},
    '{'{6'd10, 6'd0,  SIGN_NONE,           1'b0, 1'b0}, 64'd0,                  1'b0},
    '{'{6'd10, 6'd0,  sdf_pkg::SIGN_PLUS,  1'b1, 1'b0}, 64'd0,                  1'b0},
    '{'{6'd20, 6'h3F, SIGN_NONE,           1'b0, 1'b1}, 64'h8000_0000_0000_0000, 1'b1},
    '{'{6'd0,  6'h3F, SIGN_NONE,           1'b0, 1'b0}, 64'd1000000000000000000, 1'b0},
    '{'{6'd0,  6'h3F, sdf_pkg::SIGN_PLUS,  1'b0, 1'b0}, 64'd9999999999,         1'b0}
  };

  string dir_text [DIR_ROWS] = '{
    "0", "9223372036854775807", "-9223372036854775808", "-1", "", "+", " ",
    "5", "  +42", "-42  ", " 00042", "-00007", "00000005", "", "", "", "", "",
    "", "", "-9223372036854775808", "", ""
  };

  signed_decimal_field_formatter u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_value      (in_value),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_length    (out_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Builds the expected character stream for one value under fmt_cfg.
  function automatic void format_expected(logic [63:0] v);
    logic [63:0] mag;
    byte unsigned rev [40];
    byte unsigned text [80];
    byte unsigned sign_ch;
    int nat, ndig, pre, content, fw, total, pad, pos;
    sdf_pkg::res_t r;
    mag = v[63] ? -v : v;
    nat = 0;
    do begin
      rev[nat] = sdf_pkg::CH_ZERO + 8'(mag % 10);
      nat++;
      mag = mag / 10;
    end while (mag != 0);
    pre = (fmt_cfg.precision > 0) ? int'(fmt_cfg.precision) : 0;
    if (v == 0 && fmt_cfg.precision == 0)
      ndig = 0;
    else
      ndig = (nat > pre) ? nat : pre;
    if (v[63])
      sign_ch = sdf_pkg::CH_MINUS;
    else if (fmt_cfg.sign_mode == sdf_pkg::SIGN_PLUS)
      sign_ch = sdf_pkg::CH_PLUS;
    else if (fmt_cfg.sign_mode == sdf_pkg::SIGN_SPACE)
      sign_ch = sdf_pkg::CH_SPACE;
    else
      sign_ch = sdf_pkg::CH_NUL;
    content = ndig + ((sign_ch != sdf_pkg::CH_NUL) ? 1 : 0);
    fw = (fmt_cfg.min_width > sdf_pkg::CAP) ? sdf_pkg::CAP : int'(fmt_cfg.min_width);
    total = (content > fw) ? content : fw;
    pad = total - content;
    pos = 0;
    // zero padding takes priority over left adjust
    if (!fmt_cfg.zero_pad && !fmt_cfg.pad_right)
      for (int k = 0; k < pad; k++) text[pos++] = sdf_pkg::CH_SPACE;
    if (sign_ch != sdf_pkg::CH_NUL) text[pos++] = sign_ch;
    if (fmt_cfg.zero_pad)
      for (int k = 0; k < pad; k++) text[pos++] = sdf_pkg::CH_ZERO;
    for (int k = ndig; k > 0; k--)
      text[pos++] = (k - 1 < nat) ? rev[k - 1] : sdf_pkg::CH_ZERO;
    if (fmt_cfg.pad_right && !fmt_cfg.zero_pad)
      for (int k = 0; k < pad; k++) text[pos++] = sdf_pkg::CH_SPACE;
    if (total > sdf_pkg::CAP) total = sdf_pkg::CAP;
    if (total == 0) begin
      r.char_code = sdf_pkg::CH_NUL;
      r.last = 1'b1;
      r.empty_res = 1'b1;
      r.length = '0;
      pending_chars.push_back(r);
    end else begin
      for (int k = 0; k < total; k++) begin
        r.char_code = text[k];
        r.last = (k + 1 == total);
        r.empty_res = 1'b0;
        r.length = sdf_pkg::LEN_W'(total);
        pending_chars.push_back(r);
      end
    end
  endfunction

  task automatic send_value(logic [63:0] v, bit predict);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_full);
    if (predict) format_expected(v);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [5:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sdf_pkg::REG_FIELD_WIDTH: fmt_cfg.min_width = d;
      sdf_pkg::REG_PRECISION:   fmt_cfg.precision = d;
      sdf_pkg::REG_SIGN_MODE:   fmt_cfg.sign_mode = d[1:0];
      sdf_pkg::REG_LEFT_ADJUST: fmt_cfg.pad_right = d[0];
      sdf_pkg::REG_ZERO_PAD:    fmt_cfg.zero_pad = d[0];
      default: ;
    endcase
  endtask

  // Unused upper data bits get random values; the block must ignore them.
  task automatic write_cfg(sdf_pkg::cfg_t c);
    cfg_write(sdf_pkg::REG_FIELD_WIDTH, c.min_width);
    cfg_write(sdf_pkg::REG_PRECISION, c.precision);
    cfg_write(sdf_pkg::REG_SIGN_MODE, {4'($urandom_range(15)), c.sign_mode});
    cfg_write(sdf_pkg::REG_LEFT_ADJUST, {5'($urandom_range(31)), c.pad_right});
    cfg_write(sdf_pkg::REG_ZERO_PAD, {5'($urandom_range(31)), c.zero_pad});
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    sdf_pkg::res_t want, got;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_char_code, out_last, out_empty_res, out_length};
      if (pending_chars.size() == 0) begin
        $display("%0t: expected no transfer, got char 0x%h last %b empty %b len %0d", $time,
                 got.char_code, got.last, got.empty_res, got.length);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (got !== want) begin
          $display("%0t: expected char 0x%h last %b empty %b len %0d", $time,
                   want.char_code, want.last, want.empty_res, want.length);
          $display("%0t:      got char 0x%h last %b empty %b len %0d", $time,
                   got.char_code, got.last, got.empty_res, got.length);
          mismatch_count++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  initial begin
    #1_000_000;
    $display("signed_decimal_field_formatter: mismatch");
    $finish;
  end

  initial begin
    dir_row_t row;
    sdf_pkg::cfg_t phase_cfg;
    sdf_pkg::res_t r;
    logic [63:0] v, p;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.cfg != fmt_cfg) begin
        drain_results();
        write_cfg(row.cfg);
      end
      if (row.typed) begin
        len = dir_text[i].len();
        if (len == 0) begin
          r = '{sdf_pkg::CH_NUL, 1'b1, 1'b1, '0};
          pending_chars.push_back(r);
        end else begin
          for (int k = 0; k < len; k++) begin
            r = '{dir_text[i][k], (k + 1 == len), 1'b0, sdf_pkg::LEN_W'(len)};
            pending_chars.push_back(r);
          end
        end
      end
      send_value(row.value, !row.typed);
    end

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 52;
        pop_stall_pct = 30;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      case (phase)
        0: phase_cfg = '{6'd63, 6'd31, SIGN_UNUSED, 1'b1, 1'b1};
        1: phase_cfg = '{6'd0, 6'h20, SIGN_NONE, 1'b0, 1'b0};
        default: begin
          phase_cfg.min_width = ($urandom_range(3) == 0) ? 6'($urandom)
                                                         : 6'($urandom_range(24));
          case ($urandom_range(3))
            0: phase_cfg.precision = 6'h3F;
            1: phase_cfg.precision = 6'($urandom);
            default: phase_cfg.precision = 6'($urandom_range(12));
          endcase
          phase_cfg.sign_mode = 2'($urandom_range(3));
          phase_cfg.pad_right = 1'($urandom_range(1));
          phase_cfg.zero_pad = ($urandom_range(2) == 0);
        end
      endcase
      drain_results();
      write_cfg(phase_cfg);
      for (int n = 0; n < 31; n++) begin
        case ($urandom_range(6))
          0, 1, 2: v = {$urandom, $urandom};
          3: v = 64'(signed'($urandom_range(2000)) - 1000);
          4: begin
            // around powers of ten, where the digit count changes
            p = 64'd1;
            repeat ($urandom_range(19)) p = p * 10;
            v = p - 64'($urandom_range(1));
            if ($urandom_range(1)) v = -v;
          end
          5: case ($urandom_range(4))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = 64'd0;
            3: v = '1;
            default: v = 64'd1;
          endcase
          default: begin
            v = {$urandom, $urandom} >> $urandom_range(63);
            if ($urandom_range(1)) v = -v;
          end
        endcase
        send_value(v, 1'b1);
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("signed_decimal_field_formatter: match");
    else
      $display("signed_decimal_field_formatter: mismatch");
    $finish;
  end

endmodule
